@@ sv/dllc_pkg.sv @@
// ----------------------------------------------------------------------------
// dllc_pkg
// Shared types and constants for the doubly linked list with cursor: the
// command codes, the fixed field widths and the item structures that pass
// between the pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package dllc_pkg;

  localparam int CMD_W   = 4;
  localparam int FIELD_W = 32;
  localparam int COUNT_W = 5;

  typedef logic [FIELD_W-1:0] word_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR      = 4'd0,
    CMD_INS_HEAD   = 4'd1,
    CMD_INS_TAIL   = 4'd2,
    CMD_CUR_HEAD   = 4'd3,
    CMD_CUR_TAIL   = 4'd4,
    CMD_DEL_HEAD   = 4'd5,
    CMD_DEL_TAIL   = 4'd6,
    CMD_DEL_AFTER  = 4'd7,
    CMD_DEL_BEFORE = 4'd8,
    CMD_INS_AFTER  = 4'd9,
    CMD_INS_BEFORE = 4'd10,
    CMD_OVERWRITE  = 4'd11,
    CMD_NEXT       = 4'd12,
    CMD_PREV       = 4'd13,
    CMD_QUERY      = 4'd14
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    word_t            value;
  } item_t;

  typedef struct packed {
    logic   error_code;
    logic   list_empty;
    logic   cursor_active;
    word_t  head_value;
    word_t  tail_value;
    word_t  cursor_value;
    count_t node_count;
  } result_t;

endpackage

`default_nettype wire

@@ sv/doubly_linked_list_with_cursor.sv @@
// ----------------------------------------------------------------------------
// doubly_linked_list_with_cursor
// Doubly linked list of data words in a fixed node pool, with head, tail
// and cursor, driven by one command item at a time.
// ----------------------------------------------------------------------------
// The block takes one command item per clock cycle while the output is not
// stalled and presents one result item for each: the item waits in an input
// register, the list core applies it in a single pass over the register-based
// node pool (at most two chained link reads), and the result lands in an
// output register. Inserts into a full pool are dropped and flagged with
// error_code. The pool needs no clearing after reset; clear reclaims all
// nodes at once. MAX_NODES sets the pool depth and DATA_WIDTH the stored
// word width, which is at most 32 bits.
`default_nettype none

module doubly_linked_list_with_cursor #(
  parameter int MAX_NODES  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [dllc_pkg::CMD_W-1:0]           cmd,
  input  wire logic signed [dllc_pkg::FIELD_W-1:0]  value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      error_code,
  output logic                                      list_empty,
  output logic                                      cursor_active,
  output logic signed [dllc_pkg::FIELD_W-1:0]       head_value,
  output logic signed [dllc_pkg::FIELD_W-1:0]       tail_value,
  output logic signed [dllc_pkg::FIELD_W-1:0]       cursor_value,
  output logic [dllc_pkg::COUNT_W-1:0]              node_count
);

  logic              item_full;
  logic              space;
  logic              advance;
  dllc_pkg::item_t   item;
  dllc_pkg::result_t res;

  assign advance = item_full && space;

  dllc_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .value    (value),
    .take     (advance),
    .full     (item_full),
    .item     (item)
  );

  dllc_core #(
    .MAX_NODES  (MAX_NODES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (item),
    .res  (res)
  );

  dllc_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (item_full),
    .res           (res),
    .space         (space),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .error_code    (error_code),
    .list_empty    (list_empty),
    .cursor_active (cursor_active),
    .head_value    (head_value),
    .tail_value    (tail_value),
    .cursor_value  (cursor_value),
    .node_count    (node_count)
  );

endmodule

`default_nettype wire

@@ sv/dllc_in_stage.sv @@
// ----------------------------------------------------------------------------
// dllc_in_stage
// Input register. Captures one command item and holds it until the list
// core has applied it.
// ----------------------------------------------------------------------------
`default_nettype none

module dllc_in_stage (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [dllc_pkg::CMD_W-1:0]    cmd,
  input  wire logic signed [dllc_pkg::FIELD_W-1:0] value,
  input  wire logic                          take,
  output logic                               full,
  output dllc_pkg::item_t                    item
);

  assign in_stall = full && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!in_stall) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.cmd   <= cmd;
      item.value <= value;
    end
  end

endmodule

`default_nettype wire

@@ sv/dllc_core.sv @@
// ----------------------------------------------------------------------------
// dllc_core
// List state and node pool. Applies one command per step in a single pass
// and forms the result from the state after the step.
// ----------------------------------------------------------------------------
`default_nettype none

module dllc_core #(
  parameter int MAX_NODES  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  dllc_pkg::item_t   item,
  output dllc_pkg::result_t res
);

  localparam int IW = $clog2(MAX_NODES + 1);
  localparam int PW = $clog2(MAX_NODES);
  localparam int SW = (DATA_WIDTH < dllc_pkg::FIELD_W) ? DATA_WIDTH : dllc_pkg::FIELD_W;
  localparam logic [IW-1:0] NIL = IW'(MAX_NODES);

  logic [SW-1:0] pool_data [MAX_NODES];
  logic [IW-1:0] pool_next [MAX_NODES];
  logic [IW-1:0] pool_prev [MAX_NODES];

  logic [IW-1:0] head, tail, cursor, free_head, fresh, count;
  logic [IW-1:0] head_next, tail_next, cursor_next, free_head_next, fresh_next, count_next;

  logic          act;
  logic [IW-1:0] cur_fwd, cur_bwd, cur_sel;
  logic          do_clr, do_ins, do_del, do_ovw;
  logic [IW-1:0] ins_p, ins_q, del_node, del_prev, del_next;
  logic          from_free, alloc_ok, ins_ok, del_ok, err;
  logic [IW-1:0] alloc_node;

  logic          data_we;
  logic [IW-1:0] data_idx;
  logic [SW-1:0] data_val;
  logic          na_we, nb_we, pa_we, pb_we;
  logic [IW-1:0] na_idx, nb_idx, pa_idx, pb_idx;
  logic [IW-1:0] na_val, nb_val, pa_val, pb_val;

  function automatic logic is_node(input logic [IW-1:0] i);
    return i < NIL;
  endfunction

  function automatic logic [IW-1:0] link_next(input logic [IW-1:0] i);
    return is_node(i) ? pool_next[i[PW-1:0]] : NIL;
  endfunction

  function automatic logic [IW-1:0] link_prev(input logic [IW-1:0] i);
    return is_node(i) ? pool_prev[i[PW-1:0]] : NIL;
  endfunction

  function automatic logic [SW-1:0] read_after(input logic [IW-1:0] i);
    if (!is_node(i)) return '0;
    if (data_we && data_idx == i) return data_val;
    return pool_data[i[PW-1:0]];
  endfunction

  assign act     = is_node(cursor);
  assign cur_fwd = link_next(cursor);
  assign cur_bwd = link_prev(cursor);

  always_comb begin
    do_clr   = 1'b0;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    do_ovw   = 1'b0;
    ins_p    = NIL;
    ins_q    = NIL;
    del_node = NIL;
    cur_sel  = cursor;
    case (item.cmd)
      dllc_pkg::CMD_CLEAR: begin
        do_clr = 1'b1;
      end
      dllc_pkg::CMD_INS_HEAD: begin
        do_ins = 1'b1;
        ins_q  = head;
      end
      dllc_pkg::CMD_INS_TAIL: begin
        do_ins = 1'b1;
        ins_p  = tail;
      end
      dllc_pkg::CMD_CUR_HEAD: begin
        cur_sel = head;
      end
      dllc_pkg::CMD_CUR_TAIL: begin
        cur_sel = tail;
      end
      dllc_pkg::CMD_DEL_HEAD: begin
        if (cursor == head) cur_sel = NIL;
        do_del   = 1'b1;
        del_node = head;
      end
      dllc_pkg::CMD_DEL_TAIL: begin
        if (cursor == tail) cur_sel = NIL;
        do_del   = 1'b1;
        del_node = tail;
      end
      dllc_pkg::CMD_DEL_AFTER: begin
        do_del   = act;
        del_node = cur_fwd;
      end
      dllc_pkg::CMD_DEL_BEFORE: begin
        do_del   = act;
        del_node = cur_bwd;
      end
      dllc_pkg::CMD_INS_AFTER: begin
        do_ins = act;
        ins_p  = cursor;
        ins_q  = cur_fwd;
      end
      dllc_pkg::CMD_INS_BEFORE: begin
        do_ins = act;
        ins_p  = cur_bwd;
        ins_q  = cursor;
      end
      dllc_pkg::CMD_OVERWRITE: begin
        do_ovw = act;
      end
      dllc_pkg::CMD_NEXT: begin
        if (act) cur_sel = cur_fwd;
      end
      dllc_pkg::CMD_PREV: begin
        if (act) cur_sel = cur_bwd;
      end
      default: begin
      end
    endcase
  end

  assign del_ok     = do_del && is_node(del_node);
  assign del_prev   = link_prev(del_node);
  assign del_next   = link_next(del_node);
  assign from_free  = is_node(free_head);
  assign alloc_ok   = from_free || (fresh < NIL);
  assign alloc_node = from_free ? free_head : fresh;
  assign ins_ok     = do_ins && alloc_ok;
  assign err        = do_ins && !alloc_ok;

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    cursor_next    = cur_sel;
    free_head_next = free_head;
    fresh_next     = fresh;
    count_next     = count;
    data_we        = 1'b0;
    data_idx       = '0;
    data_val       = item.value[SW-1:0];
    na_we          = 1'b0;
    na_idx         = '0;
    na_val         = '0;
    nb_we          = 1'b0;
    nb_idx         = '0;
    nb_val         = '0;
    pa_we          = 1'b0;
    pa_idx         = '0;
    pa_val         = '0;
    pb_we          = 1'b0;
    pb_idx         = '0;
    pb_val         = '0;
    if (do_clr) begin
      head_next      = NIL;
      tail_next      = NIL;
      cursor_next    = NIL;
      free_head_next = NIL;
      fresh_next     = '0;
      count_next     = '0;
    end else if (ins_ok) begin
      if (from_free) begin
        free_head_next = link_next(free_head);
      end else begin
        fresh_next = fresh + IW'(1);
      end
      data_we  = 1'b1;
      data_idx = alloc_node;
      na_we    = 1'b1;
      na_idx   = alloc_node;
      na_val   = ins_q;
      pa_we    = 1'b1;
      pa_idx   = alloc_node;
      pa_val   = ins_p;
      if (ins_p == NIL) begin
        head_next = alloc_node;
      end else begin
        nb_we  = is_node(ins_p);
        nb_idx = ins_p;
        nb_val = alloc_node;
      end
      if (ins_q == NIL) begin
        tail_next = alloc_node;
      end else begin
        pb_we  = is_node(ins_q);
        pb_idx = ins_q;
        pb_val = alloc_node;
      end
      count_next = count + IW'(1);
    end else if (del_ok) begin
      if (del_prev == NIL) begin
        head_next = del_next;
      end else begin
        nb_we  = is_node(del_prev);
        nb_idx = del_prev;
        nb_val = del_next;
      end
      if (del_next == NIL) begin
        tail_next = del_prev;
      end else begin
        pb_we  = is_node(del_next);
        pb_idx = del_next;
        pb_val = del_prev;
      end
      na_we          = 1'b1;
      na_idx         = del_node;
      na_val         = free_head;
      free_head_next = del_node;
      if (count != '0) count_next = count - IW'(1);
    end else if (do_ovw) begin
      data_we  = 1'b1;
      data_idx = cursor;
    end
  end

  always_comb begin
    res.error_code    = err;
    res.list_empty    = !is_node(head_next);
    res.cursor_active = is_node(cursor_next);
    res.head_value    = dllc_pkg::word_t'(read_after(head_next));
    res.tail_value    = dllc_pkg::word_t'(read_after(tail_next));
    res.cursor_value  = dllc_pkg::word_t'(read_after(cursor_next));
    res.node_count    = dllc_pkg::count_t'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NIL;
      tail      <= NIL;
      cursor    <= NIL;
      free_head <= NIL;
      fresh     <= '0;
      count     <= '0;
    end else if (step) begin
      head      <= head_next;
      tail      <= tail_next;
      cursor    <= cursor_next;
      free_head <= free_head_next;
      fresh     <= fresh_next;
      count     <= count_next;
    end
  end

  // The released node's own link is written last so that it wins on a clash.
  always_ff @(posedge clk) begin
    if (step) begin
      if (data_we) pool_data[data_idx[PW-1:0]] <= data_val;
      if (nb_we) pool_next[nb_idx[PW-1:0]] <= nb_val;
      if (na_we) pool_next[na_idx[PW-1:0]] <= na_val;
      if (pb_we) pool_prev[pb_idx[PW-1:0]] <= pb_val;
      if (pa_we) pool_prev[pa_idx[PW-1:0]] <= pa_val;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= NIL && fresh <= NIL)
    else $error("node count or fresh pointer beyond the pool size");

  a_ends_agree: assert property (@(posedge clk) disable iff (rst)
    ((head == NIL) == (tail == NIL)) && ((head == NIL) == (count == '0)))
    else $error("head, tail and node count disagree about an empty list");

  a_cursor_in_list: assert property (@(posedge clk) disable iff (rst)
    (cursor < NIL) |-> (head < NIL))
    else $error("cursor active on an empty list");

  a_drop_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (step && err) |=> (count == $past(count) && fresh == $past(fresh)))
    else $error("dropped insert changed the pool");

endmodule

`default_nettype wire

@@ sv/dllc_out_stage.sv @@
// ----------------------------------------------------------------------------
// dllc_out_stage
// Result register. Holds one result item until the receiving side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dllc_out_stage (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  dllc_pkg::result_t                  res,
  output logic                               space,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               error_code,
  output logic                               list_empty,
  output logic                               cursor_active,
  output logic signed [dllc_pkg::FIELD_W-1:0] head_value,
  output logic signed [dllc_pkg::FIELD_W-1:0] tail_value,
  output logic signed [dllc_pkg::FIELD_W-1:0] cursor_value,
  output logic [dllc_pkg::COUNT_W-1:0]        node_count
);

  dllc_pkg::result_t held;

  assign space = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      held <= res;
    end
  end

  assign error_code    = held.error_code;
  assign list_empty    = held.list_empty;
  assign cursor_active = held.cursor_active;
  assign head_value    = held.head_value;
  assign tail_value    = held.tail_value;
  assign cursor_value  = held.cursor_value;
  assign node_count    = held.node_count;

endmodule

`default_nettype wire
